// ===== design/ndef_message_record_parser_assert.svh =====
// ----------------------------------------------------------------------------
// NDEF parser assertion macros
// Assertion macros used by the NDEF record parser core.
// ----------------------------------------------------------------------------
`ifndef NDEF_MESSAGE_RECORD_PARSER_ASSERT_SVH
`define NDEF_MESSAGE_RECORD_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define NDP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define NDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ndp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NDEF parser package
// Types and constants shared by the NDEF message record parser modules.
// ----------------------------------------------------------------------------
package ndp_pkg;

    localparam logic [7:0] TLV_START = 8'h03;
    localparam logic [7:0] TLV_END   = 8'hFE;
    localparam int unsigned FLAG_SR_BIT = 4;
    localparam int unsigned FLAG_IL_BIT = 3;

    typedef enum logic [2:0] {
        PH_START,
        PH_LENGTH,
        PH_FLAGS,
        PH_TYPELEN,
        PH_PAYLEN,
        PH_IDLEN,
        PH_BODY
    } t_phase;

    typedef enum logic [1:0] {
        KIND_RECORD,
        KIND_OK,
        KIND_BAD_START,
        KIND_BAD_END
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  record_number;
        logic [7:0]  header_flags;
        logic [7:0]  type_len;
        logic [7:0]  ident_len;
        logic [31:0] payload_len;
        logic [2:0]  type_start;
        logic [8:0]  ident_start;
        logic [9:0]  payload_start;
        logic [32:0] record_total;
    } t_result;

endpackage

// ===== design/ndp_parse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NDEF parser core
// Per-byte header decode state and record/status result generation.
// ----------------------------------------------------------------------------
`include "ndef_message_record_parser_assert.svh"

module ndp_parse_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output logic             o_res_valid,
    output ndp_pkg::t_result o_res
);
    import ndp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_cnt, n_cnt;
    logic [7:0]  r_flag, n_flag;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_pay, n_pay;
    logic [32:0] r_rem, n_rem;
    logic [7:0]  r_count, n_count;
    logic        r_start_bad, n_start_bad;

    logic [31:0] pay_shift;
    logic [7:0]  fin_ident;
    logic [31:0] fin_pay;
    logic [2:0]  tstart;
    logic [8:0]  istart;
    logic [9:0]  pstart;
    logic [32:0] total;
    logic [32:0] body_len;
    logic [32:0] rem_dec;
    logic        sr, il;
    t_kind       status_kind;

    assign sr        = r_flag[FLAG_SR_BIT];
    assign il        = r_flag[FLAG_IL_BIT];
    assign pay_shift = {r_pay[23:0], i_data_byte};
    assign fin_ident = (r_phase == PH_IDLEN) ? i_data_byte : 8'd0;
    assign fin_pay   = (r_phase == PH_PAYLEN) ? pay_shift : r_pay;
    assign tstart    = 3'd2 + (sr ? 3'd1 : 3'd4) + {2'b00, il};
    assign istart    = {6'd0, tstart} + {1'b0, r_type};
    assign pstart    = {1'b0, istart} + {2'b00, fin_ident};
    assign total     = {23'd0, pstart} + {1'b0, fin_pay};
    assign body_len  = {25'd0, r_type} + {25'd0, fin_ident} + {1'b0, fin_pay};
    assign rem_dec   = (r_rem != 33'd0) ? (r_rem - 33'd1) : r_rem;

    always_comb begin
        if (r_phase == PH_START) begin
            status_kind = (i_data_byte != TLV_START) ? KIND_BAD_START : KIND_BAD_END;
        end else if (r_start_bad) begin
            status_kind = KIND_BAD_START;
        end else begin
            status_kind = (i_data_byte == TLV_END) ? KIND_OK : KIND_BAD_END;
        end
    end

    always_comb begin
        logic fin;
        fin         = 1'b0;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_flag      = r_flag;
        n_type      = r_type;
        n_pay       = r_pay;
        n_rem       = r_rem;
        n_count     = r_count;
        n_start_bad = r_start_bad;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_adv) begin
            if (i_last_byte) begin
                o_res_valid         = 1'b1;
                o_res.kind          = status_kind;
                o_res.record_number = (status_kind == KIND_BAD_START) ? 8'd0 : r_count;
                n_phase     = PH_START;
                n_cnt       = 2'd0;
                n_flag      = 8'd0;
                n_type      = 8'd0;
                n_pay       = 32'd0;
                n_rem       = 33'd0;
                n_count     = 8'd0;
                n_start_bad = 1'b0;
            end else if (r_phase == PH_START) begin
                n_start_bad = (i_data_byte != TLV_START);
                n_phase     = PH_LENGTH;
            end else if (!r_start_bad) begin
                case (r_phase)
                    PH_LENGTH: begin
                        n_phase = PH_FLAGS;
                    end
                    PH_FLAGS: begin
                        n_flag  = i_data_byte;
                        n_phase = PH_TYPELEN;
                    end
                    PH_TYPELEN: begin
                        n_type  = i_data_byte;
                        n_pay   = 32'd0;
                        n_cnt   = 2'd0;
                        n_phase = PH_PAYLEN;
                    end
                    PH_PAYLEN: begin
                        n_pay = pay_shift;
                        if (!sr && r_cnt != 2'd3) begin
                            n_cnt = r_cnt + 2'd1;
                        end else begin
                            n_cnt = 2'd0;
                            if (il) begin
                                n_phase = PH_IDLEN;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                    end
                    PH_IDLEN: begin
                        fin = 1'b1;
                    end
                    PH_BODY: begin
                        n_rem = rem_dec;
                        if (rem_dec == 33'd0) begin
                            n_phase = PH_FLAGS;
                        end
                    end
                    default: begin
                        n_phase = PH_FLAGS;
                    end
                endcase
                if (fin) begin
                    o_res_valid         = 1'b1;
                    o_res.kind          = KIND_RECORD;
                    o_res.record_number = r_count;
                    o_res.header_flags  = r_flag;
                    o_res.type_len      = r_type;
                    o_res.ident_len     = fin_ident;
                    o_res.payload_len   = fin_pay;
                    o_res.type_start    = tstart;
                    o_res.ident_start   = istart;
                    o_res.payload_start = pstart;
                    o_res.record_total  = total;
                    if (r_count != 8'hFF) begin
                        n_count = r_count + 8'd1;
                    end
                    n_rem   = body_len;
                    n_phase = (body_len != 33'd0) ? PH_BODY : PH_FLAGS;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_cnt       <= 2'd0;
            r_flag      <= 8'd0;
            r_type      <= 8'd0;
            r_pay       <= 32'd0;
            r_rem       <= 33'd0;
            r_count     <= 8'd0;
            r_start_bad <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_flag      <= n_flag;
            r_type      <= n_type;
            r_pay       <= n_pay;
            r_rem       <= n_rem;
            r_count     <= n_count;
            r_start_bad <= n_start_bad;
        end
    end

    `NDP_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, i_adv && i_last_byte,
        r_phase == PH_START && r_count == 8'd0 && !r_start_bad,
        "final byte did not return the parser to the start state")
    `NDP_ASSERT_SAME(a_no_record_on_bad_start, i_clk, i_rst_n,
        o_res_valid && o_res.kind == KIND_RECORD, !r_start_bad,
        "record emitted for a message with a bad start byte")
    `NDP_ASSERT_NEXT(a_count_monotonic, i_clk, i_rst_n, i_adv && !i_last_byte,
        r_count >= $past(r_count),
        "record count decreased within a message")

endmodule

// ===== design/ndp_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NDEF parser result register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module ndp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_res_valid,
    input  ndp_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output ndp_pkg::t_result o_res
);
    import ndp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_adv && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_adv && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== design/ndef_message_record_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NDEF message record parser
// Decodes NDEF TLV record headers from a byte stream.
// ----------------------------------------------------------------------------
// One byte word is taken per clock when the result side is not stalled. Each
// byte is registered in the input register, decoded by the header state
// machine, and any record header or message status is then registered in the
// result register; sustained rate is one byte per cycle while the result side
// is not stalled. A record header word is emitted on the byte that completes
// the header; a status word (ok, bad start, bad end, with the record count) is
// emitted on the byte flagged last, which also restarts the parser.

module ndef_message_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_record_number,
    output logic [7:0]  o_header_flags,
    output logic [7:0]  o_type_len,
    output logic [7:0]  o_ident_len,
    output logic [31:0] o_payload_len,
    output logic [2:0]  o_type_start,
    output logic [8:0]  o_ident_start,
    output logic [9:0]  o_payload_start,
    output logic [32:0] o_record_total
);
    import ndp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       out_free;
    logic       adv;
    logic       core_valid;
    t_result    core_res;
    t_result    out_res;

    assign o_in_stall = r_in_valid && !out_free;
    assign adv        = r_in_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    ndp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_res_valid (core_valid),
        .o_res       (core_res)
    );

    ndp_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_res_valid (core_valid),
        .i_res       (core_res),
        .i_stall     (i_out_stall),
        .o_free      (out_free),
        .o_valid     (o_out_valid),
        .o_res       (out_res)
    );

    assign o_result_kind   = out_res.kind;
    assign o_record_number = out_res.record_number;
    assign o_header_flags  = out_res.header_flags;
    assign o_type_len      = out_res.type_len;
    assign o_ident_len     = out_res.ident_len;
    assign o_payload_len   = out_res.payload_len;
    assign o_type_start    = out_res.type_start;
    assign o_ident_start   = out_res.ident_start;
    assign o_payload_start = out_res.payload_start;
    assign o_record_total  = out_res.record_total;

endmodule

// ===== test/ndef_message_record_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NDEF record parser word checker
// Watches both channels of the parser. Every accepted byte word runs through
// a local copy of the header decoder, and the words it predicts are queued in
// order. Every accepted result word is compared field by field with the
// oldest queued word. Unexpected words and wrong fields are counted.
// ----------------------------------------------------------------------------
module ndef_message_record_parser_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_result_kind,
    input  logic [7:0]  i_record_number,
    input  logic [7:0]  i_header_flags,
    input  logic [7:0]  i_type_len,
    input  logic [7:0]  i_ident_len,
    input  logic [31:0] i_payload_len,
    input  logic [2:0]  i_type_start,
    input  logic [8:0]  i_ident_start,
    input  logic [9:0]  i_payload_start,
    input  logic [32:0] i_record_total,
    output int          o_fail_count,
    output int          o_pending
);
    import ndp_pkg::*;

    t_phase      phase;
    logic [1:0]  len_count;
    logic [7:0]  hdr_flags;
    logic [7:0]  hdr_type_len;
    logic [7:0]  hdr_ident_len;
    logic [31:0] hdr_payload_len;
    logic [32:0] body_left;
    logic [7:0]  rec_count;
    logic        start_bad;

    t_result awaited_words [$];

    task automatic clear_state();
        phase           = PH_START;
        len_count       = '0;
        hdr_flags       = '0;
        hdr_type_len    = '0;
        hdr_ident_len   = '0;
        hdr_payload_len = '0;
        body_left       = '0;
        rec_count       = '0;
        start_bad       = 1'b0;
    endtask

    task automatic close_header();
        t_result    r;
        logic [9:0] off_type;
        logic [9:0] off_ident;
        logic [9:0] off_payload;
        off_type    = 10'd2 + (hdr_flags[FLAG_SR_BIT] ? 10'd1 : 10'd4)
                    + (hdr_flags[FLAG_IL_BIT] ? 10'd1 : 10'd0);
        off_ident   = off_type + 10'(hdr_type_len);
        off_payload = off_ident + 10'(hdr_ident_len);
        r               = '0;
        r.kind          = KIND_RECORD;
        r.record_number = rec_count;
        r.header_flags  = hdr_flags;
        r.type_len      = hdr_type_len;
        r.ident_len     = hdr_ident_len;
        r.payload_len   = hdr_payload_len;
        r.type_start    = off_type[2:0];
        r.ident_start   = off_ident[8:0];
        r.payload_start = off_payload;
        r.record_total  = 33'(off_payload) + 33'(hdr_payload_len);
        awaited_words.push_back(r);
        if (rec_count != 8'hFF) begin
            rec_count++;
        end
        body_left = 33'(hdr_type_len) + 33'(hdr_ident_len) + 33'(hdr_payload_len);
        if (body_left != '0) begin
            phase = PH_BODY;
        end else begin
            phase = PH_FLAGS;
        end
    endtask

    task automatic parse_byte(input logic [7:0] value, input logic is_last);
        t_result r;
        t_kind   kind;
        if (is_last) begin
            if (phase == PH_START) begin
                if (value != TLV_START) begin
                    kind = KIND_BAD_START;
                end else begin
                    kind = KIND_BAD_END;
                end
            end else if (start_bad) begin
                kind = KIND_BAD_START;
            end else if (value == TLV_END) begin
                kind = KIND_OK;
            end else begin
                kind = KIND_BAD_END;
            end
            r               = '0;
            r.kind          = kind;
            r.record_number = (kind == KIND_BAD_START) ? 8'd0 : rec_count;
            awaited_words.push_back(r);
            clear_state();
        end else if (phase == PH_START) begin
            start_bad = (value != TLV_START);
            phase     = PH_LENGTH;
        end else if (!start_bad) begin
            case (phase)
                PH_LENGTH: begin
                    phase = PH_FLAGS;
                end
                PH_FLAGS: begin
                    hdr_flags     = value;
                    hdr_ident_len = '0;
                    phase         = PH_TYPELEN;
                end
                PH_TYPELEN: begin
                    hdr_type_len    = value;
                    hdr_payload_len = '0;
                    len_count       = '0;
                    phase           = PH_PAYLEN;
                end
                PH_PAYLEN: begin
                    hdr_payload_len = {hdr_payload_len[23:0], value};
                    if (!hdr_flags[FLAG_SR_BIT] && len_count < 2'd3) begin
                        len_count++;
                    end else begin
                        len_count = '0;
                        if (hdr_flags[FLAG_IL_BIT]) begin
                            phase = PH_IDLEN;
                        end else begin
                            hdr_ident_len = '0;
                            close_header();
                        end
                    end
                end
                PH_IDLEN: begin
                    hdr_ident_len = value;
                    close_header();
                end
                PH_BODY: begin
                    if (body_left != '0) begin
                        body_left--;
                    end
                    if (body_left == '0) begin
                        phase = PH_FLAGS;
                    end
                end
                default: begin
                    phase = PH_FLAGS;
                end
            endcase
        end
    endtask

    task automatic check_field(input string label, input logic [32:0] want,
                               input logic [32:0] got);
        if (got !== want) begin
            if (o_fail_count < 10) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, label, want, got);
            end
            o_fail_count++;
        end
    endtask

    task automatic compare_word();
        t_result want;
        if (awaited_words.size() == 0) begin
            if (o_fail_count < 10) begin
                $display("%0t: unexpected result word: kind %0d, record %0d",
                         $time, i_result_kind, i_record_number);
            end
            o_fail_count++;
        end else begin
            want = awaited_words.pop_front();
            check_field("result_kind",   33'(want.kind),          33'(i_result_kind));
            check_field("record_number", 33'(want.record_number), 33'(i_record_number));
            check_field("header_flags",  33'(want.header_flags),  33'(i_header_flags));
            check_field("type_len",      33'(want.type_len),      33'(i_type_len));
            check_field("ident_len",     33'(want.ident_len),     33'(i_ident_len));
            check_field("payload_len",   33'(want.payload_len),   33'(i_payload_len));
            check_field("type_start",    33'(want.type_start),    33'(i_type_start));
            check_field("ident_start",   33'(want.ident_start),   33'(i_ident_start));
            check_field("payload_start", 33'(want.payload_start), 33'(i_payload_start));
            check_field("record_total",  want.record_total,       i_record_total);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            awaited_words.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                compare_word();
            end
            if (i_in_valid && !i_in_stall) begin
                parse_byte(i_data_byte, i_last_byte);
            end
        end
        o_pending = awaited_words.size();
    end

endmodule

// ===== test/ndef_message_record_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NDEF message record parser testbench
// Feeds the parser directed corner-case messages and then random messages:
// mostly well-formed records with random content, plus truncated messages,
// bad start and end bytes, raw noise and one message long enough to saturate
// the record count. Both sides idle at random; the result side also holds
// off for long stretches so the parser backs up. A checker predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module ndef_message_record_parser_test;

    import ndp_pkg::*;

    localparam int     RESET_CYCLES = 6;
    localparam int     ITEM_TARGET  = 1600;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     DRAIN_CYCLES = 10;
    localparam longint TIMEOUT_NS   = 64'd10_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_record_number;
    logic [7:0]  o_header_flags;
    logic [7:0]  o_type_len;
    logic [7:0]  o_ident_len;
    logic [31:0] o_payload_len;
    logic [2:0]  o_type_start;
    logic [8:0]  o_ident_start;
    logic [9:0]  o_payload_start;
    logic [32:0] o_record_total;

    int         fail_count;
    int         awaited_count;
    bit         quiet;
    bit         hold_request;
    int         bytes_sent;
    logic [7:0] msg_bytes [$];

    ndef_message_record_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_kind   (o_result_kind),
        .o_record_number (o_record_number),
        .o_header_flags  (o_header_flags),
        .o_type_len      (o_type_len),
        .o_ident_len     (o_ident_len),
        .o_payload_len   (o_payload_len),
        .o_type_start    (o_type_start),
        .o_ident_start   (o_ident_start),
        .o_payload_start (o_payload_start),
        .o_record_total  (o_record_total)
    );

    ndef_message_record_parser_checker word_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_result_kind   (o_result_kind),
        .i_record_number (o_record_number),
        .i_header_flags  (o_header_flags),
        .i_type_len      (o_type_len),
        .i_ident_len     (o_ident_len),
        .i_payload_len   (o_payload_len),
        .i_type_start    (o_type_start),
        .i_ident_start   (o_ident_start),
        .i_payload_start (o_payload_start),
        .i_record_total  (o_record_total),
        .o_fail_count    (fail_count),
        .o_pending       (awaited_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        if (quiet) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 88) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= value;
        i_last_byte <= is_last;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
    endtask

    task automatic send_message();
        foreach (msg_bytes[k]) begin
            send_byte(msg_bytes[k], k == msg_bytes.size() - 1);
        end
        bytes_sent += msg_bytes.size();
        msg_bytes.delete();
    endtask

    task automatic add_record(input bit compact, input bit may_overrun);
        logic [7:0]  fl;
        logic [31:0] pl;
        int          tl;
        int          il;
        int          body;
        bit          overrun;
        fl      = 8'($urandom);
        overrun = 1'b0;
        if (compact) begin
            fl[FLAG_SR_BIT] = 1'b1;
            fl[FLAG_IL_BIT] = 1'b0;
            tl = 0;
            il = 0;
            pl = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
        end else begin
            tl = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
            il = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 3);
            pl = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 80) : $urandom_range(0, 8);
            if (may_overrun && $urandom_range(0, 3) == 0) begin
                overrun = 1'b1;
                pl      = $urandom;
            end
            if (fl[FLAG_SR_BIT]) begin
                pl[31:8] = '0;
            end
            if (!fl[FLAG_IL_BIT]) begin
                il = 0;
            end
        end
        msg_bytes.push_back(fl);
        msg_bytes.push_back(tl[7:0]);
        if (fl[FLAG_SR_BIT]) begin
            msg_bytes.push_back(pl[7:0]);
        end else begin
            msg_bytes.push_back(pl[31:24]);
            msg_bytes.push_back(pl[23:16]);
            msg_bytes.push_back(pl[15:8]);
            msg_bytes.push_back(pl[7:0]);
        end
        if (fl[FLAG_IL_BIT]) begin
            msg_bytes.push_back(il[7:0]);
        end
        body = overrun ? $urandom_range(0, 5) : tl + il + int'(pl);
        repeat (body) msg_bytes.push_back(8'($urandom));
    endtask

    task automatic build_message(input logic [7:0] start_value);
        int n;
        n = $urandom_range(0, 6);
        msg_bytes.push_back(start_value);
        msg_bytes.push_back(8'($urandom));
        for (int r = 0; r < n; r++) begin
            add_record(1'b0, r == n - 1);
        end
    endtask

    initial begin : result_sink
        int len;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                len          = HOLD_CYCLES;
            end else begin
                len = pick_gap();
            end
            if (len > 0) begin
                i_out_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            repeat ($urandom_range(0, 7)) @(posedge i_clk);
        end
    end

    initial begin : byte_source
        int         sel;
        int         trim;
        bit         saturation_done;
        logic [7:0] start_value;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_data_byte     = '0;
        i_last_byte     = 1'b0;
        quiet           = 1'b0;
        hold_request    = 1'b0;
        bytes_sent      = 0;
        saturation_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        msg_bytes = {TLV_START};
        send_message();
        msg_bytes = {TLV_END};
        send_message();
        msg_bytes = {8'h00, TLV_END};
        send_message();
        msg_bytes = {TLV_START, 8'h00, 8'hD9, 8'h01, 8'h01, 8'h01, 8'h41, 8'hA5, 8'h5A,
                     8'h10, 8'h00, 8'h00, TLV_END};
        send_message();
        msg_bytes = {TLV_START, 8'hFF, 8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h00};
        send_message();
        msg_bytes = {TLV_START, 8'h00, 8'h10, TLV_END};
        send_message();

        hold_request = 1'b1;
        while (bytes_sent < ITEM_TARGET) begin
            quiet = ($urandom_range(0, 4) == 0);
            sel   = $urandom_range(0, 99);
            if (!saturation_done && bytes_sent > 400) begin
                saturation_done = 1'b1;
                hold_request    = 1'b1;
                msg_bytes.push_back(TLV_START);
                msg_bytes.push_back(8'($urandom));
                repeat ($urandom_range(258, 262)) add_record(1'b1, 1'b0);
            end else if (sel < 65) begin
                build_message(TLV_START);
            end else if (sel < 75) begin
                build_message(TLV_START);
                trim = $urandom_range(1, 6);
                while (trim > 0 && msg_bytes.size() > 2) begin
                    void'(msg_bytes.pop_back());
                    trim--;
                end
            end else if (sel < 85) begin
                start_value = 8'($urandom);
                if (start_value == TLV_START) begin
                    start_value = ~start_value;
                end
                build_message(start_value);
            end else begin
                repeat ($urandom_range(0, 11)) msg_bytes.push_back(8'($urandom));
            end
            msg_bytes.push_back(($urandom_range(0, 6) == 0) ? 8'($urandom) : TLV_END);
            send_message();
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ndef_message_record_parser verification clean");
        end else begin
            $display("ndef_message_record_parser verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("ndef_message_record_parser verification failed");
        $finish;
    end

endmodule
